[hdl/sliding_window_statistics_defines.svh]
// Assertion macros used by the sliding window statistics RTL.
`ifndef SLIDING_WINDOW_STATISTICS_DEFINES_SVH
`define SLIDING_WINDOW_STATISTICS_DEFINES_SVH
`ifndef ASSERT_OFF
`define SWS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define SWS_ASSERT_IMPL(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) else $error(msg);
`else
`define SWS_ASSERT(lbl, prop, msg)
`define SWS_ASSERT_IMPL(lbl, pre, post, msg)
`endif
`endif

[hdl/swstat_pkg.sv]
// Types and fixed constants of the sliding window statistics block.
package swstat_pkg;
  localparam int unsigned CH_IN_W     = 3;
  localparam int unsigned WIN_W       = 11;
  localparam int unsigned COUNT_OUT_W = 11;
  localparam int unsigned VAR_W       = 47;
  localparam int unsigned STD_W       = 24;
  localparam int unsigned RAD_W       = 48;
  localparam int unsigned ROOT_STEPS  = 24;
  localparam logic [WIN_W-1:0] WINDOW_RESET = 11'd100;

  typedef enum logic [3:0] {
    ST_IDLE, ST_READ, ST_SQUARE, ST_UPDATE, ST_DIVIDE, ST_MEANSQ,
    ST_VARIANCE, ST_ROOT, ST_SCAN, ST_FLUSH, ST_FINISH
  } swstat_state_e;

  typedef struct packed {
    logic capture;
    logic rd_old;
    logic square;
    logic update;
    logic div_step;
    logic mean_sq;
    logic var_init;
    logic root_step;
    logic scan_rd;
    logic out_load;
  } swstat_cmd_t;

  typedef struct packed {
    logic div_last;
    logic root_last;
    logic scan_last;
    logic out_busy;
  } swstat_sts_t;
endpackage

[hdl/swstat_if.sv]
// Input and result channel interfaces with valid/ready handshake.
interface swstat_in_if
  import swstat_pkg::*;
#(
  parameter int unsigned SAMPLE_BITS = 24
);
  logic                          valid;
  logic                          ready;
  logic [CH_IN_W-1:0]            channel;
  logic signed [SAMPLE_BITS-1:0] sample;

  modport source (output valid, channel, sample, input ready);
  modport sink (input valid, channel, sample, output ready);
endinterface

interface swstat_out_if
  import swstat_pkg::*;
#(
  parameter int unsigned SAMPLE_BITS = 24
);
  logic                          valid;
  logic                          ready;
  logic [CH_IN_W-1:0]            channel_out;
  logic signed [SAMPLE_BITS-1:0] newest;
  logic [COUNT_OUT_W-1:0]        count;
  logic signed [SAMPLE_BITS-1:0] mean;
  logic [VAR_W-1:0]              variance;
  logic [STD_W-1:0]              std_dev;
  logic signed [SAMPLE_BITS-1:0] minimum;
  logic signed [SAMPLE_BITS-1:0] maximum;

  modport source (output valid, channel_out, newest, count, mean, variance, std_dev,
                  minimum, maximum, input ready);
  modport sink (input valid, channel_out, newest, count, mean, variance, std_dev,
                minimum, maximum, output ready);
endinterface

[hdl/swstat_ctrl.sv]
// Sequencer that steps one transaction through the statistics datapath.
module swstat_ctrl
  import swstat_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  swstat_sts_t sts_i,
  output swstat_cmd_t cmd_o
);
  swstat_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = ST_READ;
        end
      end
      ST_READ: begin
        cmd_o.rd_old = 1'b1;
        state_d      = ST_SQUARE;
      end
      ST_SQUARE: begin
        cmd_o.square = 1'b1;
        state_d      = ST_UPDATE;
      end
      ST_UPDATE: begin
        cmd_o.update = 1'b1;
        state_d      = ST_DIVIDE;
      end
      ST_DIVIDE: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_last) state_d = ST_MEANSQ;
      end
      ST_MEANSQ: begin
        cmd_o.mean_sq = 1'b1;
        state_d       = ST_VARIANCE;
      end
      ST_VARIANCE: begin
        cmd_o.var_init = 1'b1;
        state_d        = ST_ROOT;
      end
      ST_ROOT: begin
        cmd_o.root_step = 1'b1;
        if (sts_i.root_last) state_d = ST_SCAN;
      end
      ST_SCAN: begin
        cmd_o.scan_rd = 1'b1;
        if (sts_i.scan_last) state_d = ST_FLUSH;
      end
      ST_FLUSH: begin
        state_d = ST_FINISH;
      end
      ST_FINISH: begin
        if (!sts_i.out_busy) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end
endmodule

[hdl/swstat_dp.sv]
// Datapath: sample ring memory, per-channel sums, divider, square root and scan.
module swstat_dp
  import swstat_pkg::*;
#(
  parameter int unsigned CHANNELS    = 8,
  parameter int unsigned WINDOW_MAX  = 1024,
  parameter int unsigned SAMPLE_BITS = 24
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  swstat_cmd_t                   cmd_i,
  output swstat_sts_t                   sts_o,
  input  logic                          cfg_we_i,
  input  logic [WIN_W-1:0]              cfg_data_i,
  input  logic [CH_IN_W-1:0]            in_channel_i,
  input  logic signed [SAMPLE_BITS-1:0] in_sample_i,
  input  logic                          out_ready_i,
  output logic                          out_valid_o,
  output logic [CH_IN_W-1:0]            out_channel_o,
  output logic signed [SAMPLE_BITS-1:0] out_newest_o,
  output logic [COUNT_OUT_W-1:0]        out_count_o,
  output logic signed [SAMPLE_BITS-1:0] out_mean_o,
  output logic [VAR_W-1:0]              out_variance_o,
  output logic [STD_W-1:0]              out_std_dev_o,
  output logic signed [SAMPLE_BITS-1:0] out_minimum_o,
  output logic signed [SAMPLE_BITS-1:0] out_maximum_o
);
  localparam int unsigned SB      = SAMPLE_BITS;
  localparam int unsigned CH_W    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int unsigned IDX_W   = $clog2(WINDOW_MAX);
  localparam int unsigned COUNT_W = $clog2(WINDOW_MAX + 1);
  localparam int unsigned SUM_W   = SB + COUNT_W;
  localparam int unsigned SQ_W    = 2 * SB + COUNT_W - 2;
  localparam int unsigned DIV_W   = SQ_W;
  localparam int unsigned PROD_W  = 2 * SB;
  localparam int unsigned ADDR_W  = CH_W + IDX_W;
  localparam int unsigned DEPTH   = CHANNELS * (2 ** IDX_W);
  localparam int unsigned CNT_W   = $clog2(DIV_W + WINDOW_MAX + 1);
  localparam int unsigned CMP_W   = (COUNT_W > WIN_W) ? COUNT_W : WIN_W;
  localparam int unsigned REM_W   = ROOT_STEPS + 2;

  // Channel numbers fold onto the implemented channels through a small table.
  logic [CH_W-1:0] ch_map [2**CH_IN_W];
  for (genvar v = 0; v < 2**CH_IN_W; v++) begin : g_map
    assign ch_map[v] = CH_W'(v % CHANNELS);
  end

  logic [WIN_W-1:0] window_q;
  logic [COUNT_W-1:0] win_eff;
  logic [CMP_W-1:0] win_cmp;

  logic [IDX_W-1:0]        idx_q  [CHANNELS];
  logic [COUNT_W-1:0]      fill_q [CHANNELS];
  logic signed [SUM_W-1:0] sum_q  [CHANNELS];
  logic [SQ_W-1:0]         sqs_q  [CHANNELS];

  logic [SB-1:0] ring [DEPTH];
  logic signed [SB-1:0] rdata_q;

  logic [CH_W-1:0]      ch_q;
  logic [CH_IN_W-1:0]   chin_q;
  logic signed [SB-1:0] s_q;
  logic signed [SB-1:0] old_q;
  logic [PROD_W-1:0]    sq_new_q, sq_old_q;
  logic [COUNT_W-1:0]   n_q;
  logic                 neg_q;
  logic [DIV_W-1:0]     qs_q, qq_q;
  logic [COUNT_W-1:0]   rs_q, rq_q;
  logic [CNT_W-1:0]     cnt_q;
  logic [PROD_W-1:0]    mean2_q;
  logic signed [SB-1:0] mean_q;
  logic [VAR_W-1:0]     var_q;
  logic [RAD_W-1:0]     rad_q;
  logic [ROOT_STEPS-1:0] root_q;
  logic [REM_W-1:0]     rem_q;
  logic                 scan_v_q, first_q;
  logic signed [SB-1:0] min_q, max_q;

  logic [IDX_W-1:0]   cur_idx, slot, slot_next;
  logic [COUNT_W-1:0] cur_fill, fill_new;
  logic               full;
  logic [IDX_W:0]     slot_inc;
  logic signed [SB-1:0] old_sel;
  logic signed [SUM_W-1:0] sum_new;
  logic [SQ_W-1:0]    sqs_new;
  logic [SUM_W-1:0]   sum_mag;
  logic [COUNT_W:0]   rs_try, rq_try;
  logic               rs_ge, rq_ge;
  logic [SB-1:0]      mmag;
  logic [PROD_W-1:0]  msq, diff;
  logic [63:0]        diff64;
  logic [REM_W-1:0]   rem_try, trial;
  logic               mem_re;
  logic [ADDR_W-1:0]  raddr, waddr;

  always_comb begin
    win_cmp = CMP_W'(window_q);
    if (window_q == '0) begin
      win_eff = COUNT_W'(1);
    end else if (win_cmp > CMP_W'(WINDOW_MAX)) begin
      win_eff = COUNT_W'(WINDOW_MAX);
    end else begin
      win_eff = COUNT_W'(win_cmp);
    end
  end

  always_comb begin
    cur_idx   = idx_q[ch_q];
    cur_fill  = fill_q[ch_q];
    full      = cur_fill >= win_eff;
    slot      = (COUNT_W'(cur_idx) >= win_eff) ? '0 : cur_idx;
    slot_inc  = {1'b0, slot} + 1'b1;
    slot_next = (COUNT_W'(slot_inc) >= win_eff) ? '0 : slot_inc[IDX_W-1:0];
    fill_new  = full ? cur_fill : cur_fill + 1'b1;
    // Until the window has filled, the slot being replaced holds no sample.
    old_sel   = full ? rdata_q : '0;
    sum_new   = sum_q[ch_q] + SUM_W'(s_q) - SUM_W'(old_q);
    sqs_new   = sqs_q[ch_q] + SQ_W'(sq_new_q) - SQ_W'(sq_old_q);
    sum_mag   = sum_new[SUM_W-1] ? SUM_W'(-sum_new) : SUM_W'(sum_new);
    rs_try    = {rs_q, qs_q[DIV_W-1]};
    rq_try    = {rq_q, qq_q[DIV_W-1]};
    rs_ge     = rs_try >= {1'b0, n_q};
    rq_ge     = rq_try >= {1'b0, n_q};
    mmag      = qs_q[SB-1:0];
    msq       = qq_q[PROD_W-1:0];
    diff      = (msq > mean2_q) ? msq - mean2_q : '0;
    diff64    = 64'(diff);
    rem_try   = {rem_q[REM_W-3:0], rad_q[RAD_W-1 -: 2]};
    trial     = {root_q, 2'b01};
    mem_re    = cmd_i.rd_old | cmd_i.scan_rd;
    raddr     = cmd_i.scan_rd ? {ch_q, cnt_q[IDX_W-1:0]} : {ch_q, slot};
    waddr     = {ch_q, slot};
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.update) ring[waddr] <= s_q;
    if (mem_re) rdata_q <= ring[raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_q <= WINDOW_RESET;
      for (int i = 0; i < CHANNELS; i++) begin
        idx_q[i]  <= '0;
        fill_q[i] <= '0;
        sum_q[i]  <= '0;
        sqs_q[i]  <= '0;
      end
    end else if (cfg_we_i) begin
      window_q <= cfg_data_i;
      for (int i = 0; i < CHANNELS; i++) begin
        idx_q[i]  <= '0;
        fill_q[i] <= '0;
        sum_q[i]  <= '0;
        sqs_q[i]  <= '0;
      end
    end else if (cmd_i.update) begin
      idx_q[ch_q]  <= slot_next;
      fill_q[ch_q] <= fill_new;
      sum_q[ch_q]  <= sum_new;
      sqs_q[ch_q]  <= sqs_new;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      ch_q   <= ch_map[in_channel_i];
      chin_q <= CH_IN_W'(ch_map[in_channel_i]);
      s_q    <= in_sample_i;
    end
    if (cmd_i.square) begin
      old_q    <= old_sel;
      sq_new_q <= PROD_W'(s_q * s_q);
      sq_old_q <= PROD_W'(old_sel * old_sel);
    end
    if (cmd_i.update) begin
      n_q   <= fill_new;
      neg_q <= sum_new[SUM_W-1];
      qs_q  <= DIV_W'(sum_mag);
      qq_q  <= DIV_W'(sqs_new);
      rs_q  <= '0;
      rq_q  <= '0;
    end
    if (cmd_i.div_step) begin
      rs_q <= rs_ge ? COUNT_W'(rs_try - {1'b0, n_q}) : COUNT_W'(rs_try);
      rq_q <= rq_ge ? COUNT_W'(rq_try - {1'b0, n_q}) : COUNT_W'(rq_try);
      qs_q <= {qs_q[DIV_W-2:0], rs_ge};
      qq_q <= {qq_q[DIV_W-2:0], rq_ge};
    end
    if (cmd_i.mean_sq) begin
      mean2_q <= PROD_W'(mmag * mmag);
      mean_q  <= neg_q ? SB'(-mmag) : SB'(mmag);
    end
    if (cmd_i.var_init) begin
      var_q  <= diff64[VAR_W-1:0];
      rad_q  <= RAD_W'(diff64[VAR_W-1:0]);
      root_q <= '0;
      rem_q  <= '0;
    end
    if (cmd_i.root_step) begin
      rad_q <= {rad_q[RAD_W-3:0], 2'b00};
      if (rem_try >= trial) begin
        rem_q  <= rem_try - trial;
        root_q <= {root_q[ROOT_STEPS-2:0], 1'b1};
      end else begin
        rem_q  <= rem_try;
        root_q <= {root_q[ROOT_STEPS-2:0], 1'b0};
      end
    end
    if (scan_v_q) begin
      if (first_q || rdata_q < min_q) min_q <= rdata_q;
      if (first_q || rdata_q > max_q) max_q <= rdata_q;
    end
    if (cmd_i.out_load) begin
      out_channel_o  <= chin_q;
      out_newest_o   <= s_q;
      out_count_o    <= COUNT_OUT_W'(n_q);
      out_mean_o     <= mean_q;
      out_variance_o <= var_q;
      out_std_dev_o  <= root_q;
      out_minimum_o  <= min_q;
      out_maximum_o  <= max_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      scan_v_q    <= 1'b0;
      first_q     <= 1'b0;
      out_valid_o <= 1'b0;
    end else begin
      scan_v_q <= cmd_i.scan_rd;
      first_q  <= cmd_i.scan_rd && (cnt_q == '0);
      if (cmd_i.update || cmd_i.var_init) begin
        cnt_q <= '0;
      end else if (cmd_i.div_step || cmd_i.scan_rd) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (cmd_i.root_step) begin
        // The scan that follows the root starts at slot zero.
        cnt_q <= sts_o.root_last ? '0 : cnt_q + 1'b1;
      end
      if (cmd_i.out_load) begin
        out_valid_o <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_o <= 1'b0;
      end
    end
  end

  assign sts_o.div_last  = cnt_q == CNT_W'(DIV_W - 1);
  assign sts_o.root_last = cnt_q == CNT_W'(ROOT_STEPS - 1);
  assign sts_o.scan_last = cnt_q == CNT_W'(n_q) - 1'b1;
  assign sts_o.out_busy  = out_valid_o && !out_ready_i;
endmodule

[hdl/sliding_window_statistics.sv]
// Per-channel sliding window statistics: count, mean, variance, std dev, min, max.
// A transaction runs a one-bit-per-cycle divider over the square sum width, a 24-step square
// root and a scan of the valid ring entries through the ring memory's single read port.
// A new transaction is accepted only while idle, after the last result has been loaded into
// the output registers; loading waits while the previous output is still unread.
// Reset and a window write both clear all channel state; reset sets the window to 100.
module sliding_window_statistics
  import swstat_pkg::*;
#(
  parameter int unsigned CHANNELS    = 8,
  parameter int unsigned WINDOW_MAX  = 1024,
  parameter int unsigned SAMPLE_BITS = 24
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [WIN_W-1:0] cfg_data_i,
  swstat_in_if.sink        in_i,
  swstat_out_if.source     out_o
);
  `include "sliding_window_statistics_defines.svh"

  swstat_cmd_t cmd;
  swstat_sts_t sts;
  logic        in_acc;
  logic        min_le_max;
  logic        mean_in_range;

  swstat_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  swstat_dp #(
    .CHANNELS    (CHANNELS),
    .WINDOW_MAX  (WINDOW_MAX),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .cfg_we_i       (cfg_we_i),
    .cfg_data_i     (cfg_data_i),
    .in_channel_i   (in_i.channel),
    .in_sample_i    (in_i.sample),
    .out_ready_i    (out_o.ready),
    .out_valid_o    (out_o.valid),
    .out_channel_o  (out_o.channel_out),
    .out_newest_o   (out_o.newest),
    .out_count_o    (out_o.count),
    .out_mean_o     (out_o.mean),
    .out_variance_o (out_o.variance),
    .out_std_dev_o  (out_o.std_dev),
    .out_minimum_o  (out_o.minimum),
    .out_maximum_o  (out_o.maximum)
  );

  assign in_acc        = in_i.valid && in_i.ready;
  assign min_le_max    = $signed(out_o.minimum) <= $signed(out_o.maximum);
  assign mean_in_range = ($signed(out_o.mean) >= $signed(out_o.minimum)) &&
                         ($signed(out_o.mean) <= $signed(out_o.maximum));

  `SWS_ASSERT_IMPL(a_busy_after_accept, in_acc, ##1 !in_i.ready, "input accepted while busy")
  `SWS_ASSERT_IMPL(a_min_le_max, out_o.valid, min_le_max, "minimum above maximum")
  `SWS_ASSERT(a_mean_in_range, out_o.valid |-> mean_in_range, "mean outside window range")
endmodule
